// File: hdl/lfpd_pkg.sv
// shared types and constants for the line follower pid drive
`timescale 1ns / 1ps

package lfpd_pkg;

    localparam int SAMPLE_W   = 7;
    localparam int GAIN_W     = 12;
    localparam int POWER_W    = 8;
    localparam int ERR_W      = 8;
    localparam int DIFF_W     = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_CENTER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_POWER     = 3'd5;

    // register reset values
    localparam logic [SAMPLE_W-1:0] RST_STOP_THRESHOLD = 7'd30;
    localparam logic [SAMPLE_W-1:0] RST_LINE_CENTER    = 7'd32;
    localparam logic [GAIN_W-1:0]   RST_GAIN_P         = 12'd51;
    localparam logic [GAIN_W-1:0]   RST_GAIN_I         = 12'd26;
    localparam logic [GAIN_W-1:0]   RST_GAIN_D         = 12'd5;
    localparam logic [SAMPLE_W-1:0] RST_BASE_POWER     = 7'd30;

    // wheel power limit, percent
    localparam logic signed [POWER_W-1:0] POWER_LIM = 8'sd100;

    typedef struct packed {
        logic [SAMPLE_W-1:0] stop_threshold;
        logic [SAMPLE_W-1:0] line_center;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_i;
        logic [GAIN_W-1:0]   gain_d;
        logic [SAMPLE_W-1:0] base_power;
    } t_cfg;

    typedef struct packed {
        logic signed [POWER_W-1:0] left;
        logic signed [POWER_W-1:0] right;
        logic                      stopped;
    } t_drive;

endpackage

// File: hdl/lfpd_cfg_regs.sv
// configuration register file of the line follower pid drive
`timescale 1ns / 1ps

module lfpd_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output lfpd_pkg::t_cfg                  o_cfg
);
    import lfpd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STOP_THRESHOLD: n_cfg.stop_threshold = i_cfg_data[SAMPLE_W-1:0];
                CFG_LINE_CENTER:    n_cfg.line_center    = i_cfg_data[SAMPLE_W-1:0];
                CFG_GAIN_P:         n_cfg.gain_p         = i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:         n_cfg.gain_i         = i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:         n_cfg.gain_d         = i_cfg_data[GAIN_W-1:0];
                CFG_BASE_POWER:     n_cfg.base_power     = i_cfg_data[SAMPLE_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_threshold <= RST_STOP_THRESHOLD;
            r_cfg.line_center    <= RST_LINE_CENTER;
            r_cfg.gain_p         <= RST_GAIN_P;
            r_cfg.gain_i         <= RST_GAIN_I;
            r_cfg.gain_d         <= RST_GAIN_D;
            r_cfg.base_power     <= RST_BASE_POWER;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/lfpd_pid_core.sv
// pid datapath: error, integral, derivative, correction and wheel power limits
`timescale 1ns / 1ps

module lfpd_pid_core #(
    parameter int SUM_WIDTH = 16
) (
    input  lfpd_pkg::t_cfg                        i_cfg,
    input  logic [lfpd_pkg::SAMPLE_W-1:0]         i_line,
    input  logic [lfpd_pkg::SAMPLE_W-1:0]         i_stop,
    input  logic signed [SUM_WIDTH-1:0]           i_sum,
    input  logic signed [lfpd_pkg::ERR_W-1:0]     i_last,
    output logic signed [SUM_WIDTH-1:0]           o_sum,
    output logic signed [lfpd_pkg::ERR_W-1:0]     o_last,
    output lfpd_pkg::t_drive                      o_drive
);
    import lfpd_pkg::*;

    localparam int P_W   = GAIN_W + 1 + ERR_W;
    localparam int I_W   = GAIN_W + 1 + SUM_WIDTH;
    localparam int D_W   = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W = SUM_WIDTH + GAIN_W + 3;
    localparam int PWR_W = ACC_W - 7;

    localparam logic signed [SUM_WIDTH:0] SUM_MAX = {2'b00, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH:0] SUM_MIN = -SUM_MAX;

    logic                       stop_hit;
    logic signed [ERR_W-1:0]    err;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [SUM_WIDTH:0]  sum_ext;
    logic signed [SUM_WIDTH:0]  sum_sat;
    logic signed [GAIN_W:0]     gp_s, gi_s, gd_s;
    logic signed [P_W-1:0]      p_prod;
    logic signed [I_W-1:0]      i_prod;
    logic signed [D_W-1:0]      d_prod;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-9:0]    corr;
    logic signed [PWR_W-1:0]    base_ext, left_w, right_w, lim_hi, lim_lo;
    logic signed [POWER_W-1:0]  left_sat, right_sat;

    assign stop_hit = (i_stop >= i_cfg.stop_threshold);

    assign err  = $signed({1'b0, i_cfg.line_center}) - $signed({1'b0, i_line});
    assign diff = DIFF_W'(err) - DIFF_W'(i_last);

    // integral saturates symmetrically
    assign sum_ext = (SUM_WIDTH+1)'(i_sum) + (SUM_WIDTH+1)'(err);
    always_comb begin
        priority if (sum_ext > SUM_MAX) begin
            sum_sat = SUM_MAX;
        end else if (sum_ext < SUM_MIN) begin
            sum_sat = SUM_MIN;
        end else begin
            sum_sat = sum_ext;
        end
    end

    // three independent products, unsigned gains made signed
    assign gp_s   = $signed({1'b0, i_cfg.gain_p});
    assign gi_s   = $signed({1'b0, i_cfg.gain_i});
    assign gd_s   = $signed({1'b0, i_cfg.gain_d});
    assign p_prod = P_W'(gp_s) * P_W'(err);
    assign i_prod = I_W'(gi_s) * I_W'(sum_sat);
    assign d_prod = D_W'(gd_s) * D_W'(diff);

    assign acc  = ACC_W'(p_prod) + ACC_W'(i_prod) + ACC_W'(d_prod);
    // dropping the low byte of a signed value rounds toward minus infinity
    assign corr = acc[ACC_W-1:8];

    assign base_ext = $signed({{(PWR_W-SAMPLE_W){1'b0}}, i_cfg.base_power});
    assign left_w   = base_ext - PWR_W'(corr);
    assign right_w  = base_ext + PWR_W'(corr);
    assign lim_hi   = PWR_W'(POWER_LIM);
    assign lim_lo   = -lim_hi;

    always_comb begin
        priority if (left_w > lim_hi) begin
            left_sat = POWER_LIM;
        end else if (left_w < lim_lo) begin
            left_sat = -POWER_LIM;
        end else begin
            left_sat = left_w[POWER_W-1:0];
        end
        priority if (right_w > lim_hi) begin
            right_sat = POWER_LIM;
        end else if (right_w < lim_lo) begin
            right_sat = -POWER_LIM;
        end else begin
            right_sat = right_w[POWER_W-1:0];
        end
    end

    always_comb begin
        if (stop_hit) begin
            o_sum           = '0;
            o_last          = '0;
            o_drive.left    = '0;
            o_drive.right   = '0;
            o_drive.stopped = 1'b1;
        end else begin
            o_sum           = sum_sat[SUM_WIDTH-1:0];
            o_last          = err;
            o_drive.left    = left_sat;
            o_drive.right   = right_sat;
            o_drive.stopped = 1'b0;
        end
    end

endmodule

// File: hdl/line_follow_pid_drive.sv
// top level of the pid line follower with differential drive outputs
`timescale 1ns / 1ps

// path: an accepted item lands in the input register, its result is then registered in
//   the result register and shown from then on
// throughput: one item per cycle while the drive side does not stall; the integral and
//   previous error close their loop through the combinational pid datapath
// reset: synchronous active low; clears valids, integral, previous error, and loads
//   the register defaults

module line_follow_pid_drive #(
    parameter int SUM_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // sensor item channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [lfpd_pkg::SAMPLE_W-1:0]      i_line_sample,
    input  logic [lfpd_pkg::SAMPLE_W-1:0]      i_stop_sample,
    // drive item channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [lfpd_pkg::POWER_W-1:0] o_left_power,
    output logic signed [lfpd_pkg::POWER_W-1:0] o_right_power,
    output logic                               o_stopped
);
    import lfpd_pkg::*;

    t_cfg cfg;

    // input register
    logic                      r_in_valid;
    logic [SAMPLE_W-1:0]       r_line;
    logic [SAMPLE_W-1:0]       r_stop;

    // controller state
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic signed [ERR_W-1:0]     r_last;
    logic signed [SUM_WIDTH-1:0] n_sum;
    logic signed [ERR_W-1:0]     n_last;

    // result register
    logic                      r_out_valid;
    t_drive                    r_drive;
    t_drive                    n_drive;

    logic                      out_free;
    logic                      advance;
    logic                      in_accept;

    lfpd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lfpd_pid_core #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_core (
        .i_cfg   (cfg),
        .i_line  (r_line),
        .i_stop  (r_stop),
        .i_sum   (r_sum),
        .i_last  (r_last),
        .o_sum   (n_sum),
        .o_last  (n_last),
        .o_drive (n_drive)
    );

    // the result register frees up when empty or when its item is taken
    assign out_free   = !r_out_valid || !i_out_stall;
    // the item in the input register moves on and commits its state update
    assign advance    = r_in_valid && out_free;
    // stall only while a held item cannot move on
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_line <= i_line_sample;
            r_stop <= i_stop_sample;
        end
    end

    // integral and previous error follow the items in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_last <= '0;
        end else if (advance) begin
            r_sum  <= n_sum;
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_drive <= n_drive;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_left_power  = r_drive.left;
    assign o_right_power = r_drive.right;
    assign o_stopped     = r_drive.stopped;

    // integral never leaves its symmetric limit
    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum != {1'b1, {(SUM_WIDTH-1){1'b0}}}))
        else $error("integral reached the negative extreme");

    // a stop item clears the controller state
    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_drive.stopped) |=> (r_sum == '0 && r_last == '0))
        else $error("stop item did not clear integral and previous error");

    // a stopped result carries zero power
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_drive.stopped) |-> (r_drive.left == '0 && r_drive.right == '0))
        else $error("stopped result with nonzero power");

    // wheel power stays within the drive limit
    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_drive.left <= POWER_LIM && r_drive.left >= -POWER_LIM
                         && r_drive.right <= POWER_LIM && r_drive.right >= -POWER_LIM))
        else $error("wheel power out of range");

    // the input side stalls only behind a full and stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall && r_in_valid))
        else $error("input stalled without a blocked result");

endmodule

// File: sim/line_follow_pid_drive_tb.sv
// self-checking testbench for the pid line follower differential drive
`timescale 1ns / 1ps

module line_follow_pid_drive_tb;
    import lfpd_pkg::*;

    // integral width of the instance, also used by the predictor
    localparam int     SUM_W        = 16;
    localparam longint SUM_LIM      = (longint'(1) << (SUM_W - 1)) - 1;
    localparam int     SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
    localparam int     PERCENT_MAX  = 100;
    localparam int     CFG_DATA_MAX = (1 << CFG_DATA_W) - 1;
    // longest random gap on the sensor side and longest stall on the drive side
    localparam int     MAX_IDLE     = 16;
    // settling margin after the last owed drive item has come out
    localparam int     DRAIN_CYCLES = 4;
    // cycles without any accepted item, taken drive item or register write before the run is declared hung
    localparam int     HANG_LIMIT   = 1000;
    // indexes past the last register, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_BASE_POWER + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_BASE_POWER + 3'd2;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_idx;
    logic [CFG_DATA_W-1:0]        i_cfg_data;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [SAMPLE_W-1:0]          i_line_sample;
    logic [SAMPLE_W-1:0]          i_stop_sample;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic signed [POWER_W-1:0]    o_left_power;
    logic signed [POWER_W-1:0]    o_right_power;
    logic                         o_stopped;

    // predictor state: register copy, integral and previous error
    t_cfg   drive_cfg;
    longint pid_integral;
    longint pid_prev_err;

    // drive items still owed by the block, oldest first
    t_drive drive_expected[$];

    int mismatch_cnt   = 0;
    int idle_cycles    = 0;
    int out_stall_left = 0;
    // burst flags switch the random gaps off for a stretch of items
    bit in_burst       = 1'b0;
    bit out_burst      = 1'b0;

    line_follow_pid_drive #(
        .SUM_WIDTH     (SUM_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_line_sample (i_line_sample),
        .i_stop_sample (i_stop_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_left_power  (o_left_power),
        .o_right_power (o_right_power),
        .o_stopped     (o_stopped)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // symmetric saturation, used for the integral and both wheels
    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // next drive item for one sensor item, advances the pid state
    function automatic t_drive predict_drive(input logic [SAMPLE_W-1:0] line,
                                             input logic [SAMPLE_W-1:0] stop);
        t_drive res;
        longint err;
        longint diff;
        longint accum;
        longint corr;
        longint left;
        longint right;
        // stop line seen: zero drive, integral and previous error cleared
        if (stop >= drive_cfg.stop_threshold) begin
            pid_integral = 0;
            pid_prev_err = 0;
            res.left     = '0;
            res.right    = '0;
            res.stopped  = 1'b1;
            return res;
        end
        err          = longint'(drive_cfg.line_center) - longint'(line);
        pid_integral = clamp_sym(pid_integral + err, SUM_LIM);
        diff         = err - pid_prev_err;
        pid_prev_err = err;
        accum = longint'(drive_cfg.gain_p) * err
              + longint'(drive_cfg.gain_i) * pid_integral
              + longint'(drive_cfg.gain_d) * diff;
        // arithmetic shift of a signed value rounds toward minus infinity
        corr  = accum >>> 8;
        left  = clamp_sym(longint'(drive_cfg.base_power) - corr, longint'(POWER_LIM));
        right = clamp_sym(longint'(drive_cfg.base_power) + corr, longint'(POWER_LIM));
        res.left    = left[POWER_W-1:0];
        res.right   = right[POWER_W-1:0];
        res.stopped = 1'b0;
        return res;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_cnt++;
        end
    endtask

    // sensor side: every accepted item goes through the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            drive_expected.push_back(predict_drive(i_line_sample, i_stop_sample));
    end

    // drive side: check each accepted item, then draw the stall for the next one
    always @(posedge i_clk) begin
        t_drive exp_drive;
        if (!i_rst_n) begin
            i_out_stall    <= 1'b0;
            out_stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (drive_expected.size() == 0) begin
                    $display("%0t: unexpected drive item, actual left %0d right %0d stopped %0b",
                             $time, o_left_power, o_right_power, o_stopped);
                    mismatch_cnt++;
                end else begin
                    exp_drive = drive_expected.pop_front();
                    check_field("left_power", int'(exp_drive.left), int'(o_left_power));
                    check_field("right_power", int'(exp_drive.right), int'(o_right_power));
                    check_field("stopped", int'(exp_drive.stopped), int'(o_stopped));
                end
                if ($urandom_range(0, 31) == 0)
                    out_burst = !out_burst;
                out_stall_left = out_burst ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (out_stall_left > 0) begin
                i_out_stall <= 1'b1;
                out_stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // hang detection: any accepted item or register write restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, HANG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // offer one sensor item after a random gap and hold it until accepted
    task automatic send_item(input int line, input int stop);
        int gap;
        if ($urandom_range(0, 31) == 0)
            in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_line_sample <= SAMPLE_W'(line);
        i_stop_sample <= SAMPLE_W'(stop);
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // stop offering items and let every owed drive item come out
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (drive_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write, mirrored into the predictor copy
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        logic [CFG_DATA_W-1:0] data_bits;
        data_bits  = CFG_DATA_W'(data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data_bits;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_STOP_THRESHOLD: drive_cfg.stop_threshold = data_bits[SAMPLE_W-1:0];
            CFG_LINE_CENTER:    drive_cfg.line_center    = data_bits[SAMPLE_W-1:0];
            CFG_GAIN_P:         drive_cfg.gain_p         = data_bits[GAIN_W-1:0];
            CFG_GAIN_I:         drive_cfg.gain_i         = data_bits[GAIN_W-1:0];
            CFG_GAIN_D:         drive_cfg.gain_d         = data_bits[GAIN_W-1:0];
            CFG_BASE_POWER:     drive_cfg.base_power     = data_bits[SAMPLE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // register value biased toward the extremes, sometimes wider than the register
    function automatic int pick_reg_value(input int top);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return top;
            2:       return CFG_DATA_MAX;
            3:       return int'($urandom_range(0, CFG_DATA_MAX));
            default: return int'($urandom_range(0, top));
        endcase
    endfunction

    // mostly below the threshold so the loop keeps running, sometimes anything
    function automatic int pick_stop();
        if (drive_cfg.stop_threshold == 0 || $urandom_range(0, 3) == 0)
            return $urandom_range(0, SAMPLE_MAX);
        return $urandom_range(0, drive_cfg.stop_threshold - 1);
    endfunction

    task automatic tune_random();
        settle_idle();
        write_reg(CFG_STOP_THRESHOLD, pick_reg_value(PERCENT_MAX));
        write_reg(CFG_LINE_CENTER, pick_reg_value(PERCENT_MAX));
        write_reg(CFG_GAIN_P, pick_reg_value(CFG_DATA_MAX));
        write_reg(CFG_GAIN_I, pick_reg_value(CFG_DATA_MAX));
        write_reg(CFG_GAIN_D, pick_reg_value(CFG_DATA_MAX));
        write_reg(CFG_BASE_POWER, pick_reg_value(PERCENT_MAX));
    endtask

    // reset values: zero error, both error signs, stop exactly at the threshold
    task automatic test_default_registers();
        send_item(32, 0);
        send_item(0, 0);
        send_item(100, 0);
        send_item(SAMPLE_MAX, 29);
        send_item(SAMPLE_MAX, 30);
        send_item(64, 29);
        send_item(0, SAMPLE_MAX);
        send_item(SAMPLE_MAX, 0);
        send_item(1, 1);
        settle_idle();
    endtask

    // every register at its top and bottom, out of range values, spare indexes
    task automatic test_register_extremes();
        // all ones: 7 bit registers land at 127, beyond the percent range
        write_reg(CFG_STOP_THRESHOLD, CFG_DATA_MAX);
        write_reg(CFG_LINE_CENTER, CFG_DATA_MAX);
        write_reg(CFG_GAIN_P, CFG_DATA_MAX);
        write_reg(CFG_GAIN_I, CFG_DATA_MAX);
        write_reg(CFG_GAIN_D, CFG_DATA_MAX);
        write_reg(CFG_BASE_POWER, CFG_DATA_MAX);
        send_item(0, 0);
        send_item(SAMPLE_MAX, SAMPLE_MAX - 1);
        send_item(SAMPLE_MAX, SAMPLE_MAX);
        send_item(0, SAMPLE_MAX - 1);
        send_item(64, 100);
        settle_idle();
        // all zero: a zero threshold stops on every item
        write_reg(CFG_STOP_THRESHOLD, 0);
        write_reg(CFG_LINE_CENTER, 0);
        write_reg(CFG_GAIN_P, 0);
        write_reg(CFG_GAIN_I, 0);
        write_reg(CFG_GAIN_D, 0);
        write_reg(CFG_BASE_POWER, 0);
        send_item(0, 0);
        send_item(SAMPLE_MAX, SAMPLE_MAX);
        settle_idle();
        // zero gains and base give zero drive while running
        write_reg(CFG_STOP_THRESHOLD, 1);
        write_reg(CFG_SPARE_LO, CFG_DATA_MAX);
        write_reg(CFG_SPARE_HI, CFG_DATA_MAX);
        send_item(SAMPLE_MAX, 0);
        send_item(0, 0);
        settle_idle();
        // full gains: both wheels pinned at the limits
        write_reg(CFG_LINE_CENTER, PERCENT_MAX);
        write_reg(CFG_GAIN_P, CFG_DATA_MAX);
        write_reg(CFG_GAIN_I, CFG_DATA_MAX);
        write_reg(CFG_GAIN_D, CFG_DATA_MAX);
        write_reg(CFG_BASE_POWER, PERCENT_MAX);
        send_item(0, 0);
        send_item(PERCENT_MAX, 0);
        send_item(SAMPLE_MAX, 0);
        send_item(0, 0);
        settle_idle();
    endtask

    // random settings with random samples, stops mixed in
    task automatic test_random_tuning();
        repeat (4) begin
            tune_random();
            repeat (25) send_item($urandom_range(0, SAMPLE_MAX), pick_stop());
        end
        settle_idle();
    endtask

    // long runs of one-sided error drive the integral into both limits
    task automatic test_integral_windup();
        write_reg(CFG_STOP_THRESHOLD, SAMPLE_MAX);
        write_reg(CFG_LINE_CENTER, SAMPLE_MAX);
        write_reg(CFG_GAIN_P, pick_reg_value(CFG_DATA_MAX));
        write_reg(CFG_GAIN_I, int'($urandom_range(0, 3)));
        write_reg(CFG_GAIN_D, pick_reg_value(CFG_DATA_MAX));
        write_reg(CFG_BASE_POWER, int'($urandom_range(0, PERCENT_MAX)));
        repeat (270) send_item($urandom_range(0, 2), $urandom_range(0, SAMPLE_MAX - 1));
        // stop item clears the integral before the other side
        send_item($urandom_range(0, SAMPLE_MAX), SAMPLE_MAX);
        settle_idle();
        write_reg(CFG_LINE_CENTER, 0);
        write_reg(CFG_GAIN_I, int'($urandom_range(0, 3)));
        repeat (270) send_item($urandom_range(SAMPLE_MAX - 2, SAMPLE_MAX),
                               $urandom_range(0, SAMPLE_MAX - 1));
        send_item($urandom_range(0, SAMPLE_MAX), SAMPLE_MAX);
        settle_idle();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_STOP_THRESHOLD;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_line_sample <= '0;
        i_stop_sample <= '0;
        drive_cfg = '{RST_STOP_THRESHOLD, RST_LINE_CENTER, RST_GAIN_P,
                      RST_GAIN_I, RST_GAIN_D, RST_BASE_POWER};
        pid_integral = 0;
        pid_prev_err = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_registers();
        test_register_extremes();
        test_random_tuning();
        test_integral_windup();

        settle_idle();
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
